FILE: design/euq_pkg.sv
// euler-to-quaternion shared types, constants and fixed-point helpers
// used by every cell and the top level; depends on nothing

package euq_pkg;

  // internal Q30 word, wide enough for the root argument and the numerators
  localparam int unsigned CW = 34;
  typedef logic signed [CW-1:0] fx_t;

  localparam fx_t FX_PI      = 34'sd3373259426;
  localparam fx_t FX_HALF_PI = 34'sd1686629713;
  localparam fx_t FX_ONE     = 34'sd1073741824;
  localparam fx_t FX_GAIN    = 34'sd652032874;
  localparam logic signed [39:0] FX_TWO_PI = 40'sd6746518852;

  // lane order inside every row: heading, attitude, bank
  localparam int unsigned LANES = 3;

  typedef struct packed {
    fx_t  x;
    fx_t  y;
    fx_t  a;
    logic neg;
  } cor_lane_t;

  typedef struct packed {
    cor_lane_t [LANES-1:0] lane;
  } cor_t;

  typedef struct packed {
    logic [63:0]           rem;
    logic [63:0]           root;
    fx_t  [LANES-1:0]      num;
    logic                  nonpos;
  } sq_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [30:0] quo;
    logic        neg;
    logic        sat;
  } dv_lane_t;

  typedef struct packed {
    dv_lane_t [LANES-1:0] lane;
    logic [32:0]          den;
    logic [30:0]          w;
    logic                 deg;
  } dv_t;

  function automatic fx_t atan_q30(input int unsigned idx);
    fx_t r;
    case (idx)
      0:  r = 34'h3243F6A8;  1:  r = 34'h1DAC6705;  2:  r = 34'h0FADBAFC;
      3:  r = 34'h07F56EA6;  4:  r = 34'h03FEAB76;  5:  r = 34'h01FFD55B;
      6:  r = 34'h00FFFAAA;  7:  r = 34'h007FFF55;  8:  r = 34'h003FFFEA;
      9:  r = 34'h001FFFFD;  10: r = 34'h000FFFFF;  11: r = 34'h0007FFFF;
      12: r = 34'h0003FFFF;  13: r = 34'h0001FFFF;  14: r = 34'h0000FFFF;
      15: r = 34'h00007FFF;  16: r = 34'h00003FFF;  17: r = 34'h00001FFF;
      18: r = 34'h00000FFF;  19: r = 34'h000007FF;  20: r = 34'h000003FF;
      21: r = 34'h000001FF;  22: r = 34'h000000FF;  23: r = 34'h0000007F;
      24: r = 34'h0000003F;  25: r = 34'h0000001F;  26: r = 34'h0000000F;
      27: r = 34'h00000008;  28: r = 34'h00000004;  29: r = 34'h00000002;
      30: r = 34'h00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

  // q30 product with floor
  function automatic fx_t mulq(input fx_t a, input fx_t b);
    logic signed [2*CW-1:0] p;
    p = a * b;
    return fx_t'(p >>> 30);
  endfunction

endpackage

FILE: design/euq_in_if.sv
// input channel: three euler angles with valid/ready handshake
// depends on nothing

interface euq_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] heading_angle;
  logic signed [15:0] attitude_angle;
  logic signed [15:0] bank_angle;

  modport source (output valid, heading_angle, attitude_angle, bank_angle, input ready);
  modport sink   (input valid, heading_angle, attitude_angle, bank_angle, output ready);
endinterface

FILE: design/euq_out_if.sv
// output channel: quaternion and degenerate flag with valid/ready handshake
// depends on nothing

interface euq_out_if;
  logic               valid;
  logic               ready;
  logic        [14:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic               degenerate;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, degenerate, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, degenerate, output ready);
endinterface

FILE: design/euq_cordic_cell.sv
// one rotation-mode cordic iteration for all three angle lanes
// depends on euq_pkg

module euq_cordic_cell import euq_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  cor_t data_i,
  output logic valid_o,
  output cor_t data_o
);

  cor_t data_d, data_q;
  logic valid_q;

  always_comb begin
    data_d = data_i;
    for (int l = 0; l < LANES; l++) begin
      if (!data_i.lane[l].a[CW-1]) begin
        data_d.lane[l].x = data_i.lane[l].x - (data_i.lane[l].y >>> STAGE);
        data_d.lane[l].y = data_i.lane[l].y + (data_i.lane[l].x >>> STAGE);
        data_d.lane[l].a = data_i.lane[l].a - atan_q30(STAGE);
      end else begin
        data_d.lane[l].x = data_i.lane[l].x + (data_i.lane[l].y >>> STAGE);
        data_d.lane[l].y = data_i.lane[l].y - (data_i.lane[l].x >>> STAGE);
        data_d.lane[l].a = data_i.lane[l].a + atan_q30(STAGE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: design/euq_sqrt_cell.sv
// one digit of the integer square root, remainder form
// depends on euq_pkg

module euq_sqrt_cell import euq_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  sq_t  data_i,
  output logic valid_o,
  output sq_t  data_o
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  sq_t         data_d, data_q;
  logic        valid_q;
  logic [63:0] trial;

  always_comb begin
    data_d = data_i;
    trial  = data_i.root + BIT;
    if (data_i.rem >= trial) begin
      data_d.rem  = data_i.rem - trial;
      data_d.root = (data_i.root >> 1) + BIT;
    end else begin
      data_d.root = data_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: design/euq_div_cell.sv
// one quotient bit of the restoring divide, three lanes sharing a divisor
// depends on euq_pkg

module euq_div_cell import euq_pkg::*; #(
  parameter int unsigned QBIT = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  dv_t  data_i,
  output logic valid_o,
  output dv_t  data_o
);

  dv_t         data_d, data_q;
  logic        valid_q;
  logic [65:0] sub;

  always_comb begin
    data_d = data_i;
    sub    = 66'(data_i.den) << QBIT;
    for (int l = 0; l < LANES; l++) begin
      if (!data_i.lane[l].sat && ({2'b00, data_i.lane[l].rem} >= sub)) begin
        data_d.lane[l].rem       = data_i.lane[l].rem - sub[63:0];
        data_d.lane[l].quo[QBIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: design/euler_to_quaternion_unit.sv
// euler angles to quaternion, top level: wrap, cordic row, products, root row,
// divide row and output register; depends on euq_pkg, euq_in_if, euq_out_if
// and the cordic, sqrt and divide cells
//
// usage
//   in_i  : heading, attitude and bank angles (signed, ANGLE_FRAC_BITS frac)
//   out_o : quat_w (unsigned) and quat_x/y/z (signed), QUAT_FRAC_BITS frac,
//           plus a degenerate flag that zeroes all four components
//   one transfer in per cycle unless out_o stalls, one result out per transfer, in order
//   pipeline stages, in order:
//     1 wrap/fold, CORDIC_STAGES cordic cells, 3 product/sum stages,
//     32 root cells, 1 divide setup, QUAT_FRAC_BITS+1 divide cells, 1 output
//   the root row (32 cells, one result bit each) and the divide row (one
//   quotient bit per cell) set the depth; every cell works on a new item
//   each cycle unless the row is frozen, so throughput is one item per clock
//   the whole row advances together; when out_o stalls with a result held,
//   the row freezes and in_i.ready drops in the same cycle, nothing is lost
//   reset clears only the valid bits; the row comes up empty and ready

module euler_to_quaternion_unit import euq_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = 13,
  parameter int unsigned QUAT_FRAC_BITS  = 14,
  parameter int unsigned CORDIC_STAGES   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  euq_in_if.sink    in_i,
  euq_out_if.source out_o
);

  localparam int unsigned WRAP_BITS = (ANGLE_FRAC_BITS < 13) ? 13 - ANGLE_FRAC_BITS : 0;
  localparam int unsigned QF        = QUAT_FRAC_BITS;
  localparam logic [30:0] LIM       = 31'd1 << QF;

  // global advance: the row moves whenever the output slot is free or leaving
  logic en;
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // angle wrap into [-pi, pi] then fold into [-pi/2, pi/2]
  function automatic cor_lane_t wrap_fold(input logic signed [15:0] v);
    logic signed [39:0] a;
    logic signed [39:0] step;
    cor_lane_t          r;
    a = 40'(v) <<< (30 - ANGLE_FRAC_BITS);
    for (int j = int'(WRAP_BITS) - 1; j >= 0; j--) begin
      step = FX_TWO_PI <<< j;
      if (a > 40'(FX_PI) + step) begin
        a = a - step;
      end else if (a < -40'(FX_PI) - step) begin
        a = a + step;
      end
    end
    if (a > 40'(FX_PI)) begin
      a = a - FX_TWO_PI;
    end else if (a < -40'(FX_PI)) begin
      a = a + FX_TWO_PI;
    end
    r.neg = 1'b0;
    if (a > 40'(FX_HALF_PI)) begin
      a     = 40'(FX_PI) - a;
      r.neg = 1'b1;
    end else if (a < -40'(FX_HALF_PI)) begin
      a     = -40'(FX_PI) - a;
      r.neg = 1'b1;
    end
    r.a = fx_t'(a);
    r.x = FX_GAIN;
    r.y = '0;
    return r;
  endfunction

  // cordic row
  cor_t cor_data [0:CORDIC_STAGES];
  logic cor_vld  [0:CORDIC_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cor_vld[0] <= 1'b0;
    end else if (en) begin
      cor_vld[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cor_data[0].lane[0] <= wrap_fold(in_i.heading_angle);
      cor_data[0].lane[1] <= wrap_fold(in_i.attitude_angle);
      cor_data[0].lane[2] <= wrap_fold(in_i.bank_angle);
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    euq_cordic_cell #(.STAGE(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cor_vld[g]),
      .data_i  (cor_data[g]),
      .valid_o (cor_vld[g+1]),
      .data_o  (cor_data[g+1])
    );
  end

  // sines and cosines off the end of the row
  fx_t s1, c1, s2, c2, s3, c3;
  assign s1 = cor_data[CORDIC_STAGES].lane[0].y;
  assign s2 = cor_data[CORDIC_STAGES].lane[1].y;
  assign s3 = cor_data[CORDIC_STAGES].lane[2].y;
  assign c1 = cor_data[CORDIC_STAGES].lane[0].neg ? -cor_data[CORDIC_STAGES].lane[0].x
                                                  :  cor_data[CORDIC_STAGES].lane[0].x;
  assign c2 = cor_data[CORDIC_STAGES].lane[1].neg ? -cor_data[CORDIC_STAGES].lane[1].x
                                                  :  cor_data[CORDIC_STAGES].lane[1].x;
  assign c3 = cor_data[CORDIC_STAGES].lane[2].neg ? -cor_data[CORDIC_STAGES].lane[2].x
                                                  :  cor_data[CORDIC_STAGES].lane[2].x;

  // pair products
  logic p1_vld_q, p2_vld_q, p3_vld_q;
  fx_t  c1c2_q, c1c3_q, c2c3_q, s1s2_q, c2s3_q, c1s3_q, s1c2_q, s1c3_q, c1s2_q, s1s3_q;
  fx_t  p1_s2_q, p1_s3_q, p1_c3_q;
  // triple products
  fx_t  sss_q, ssc_q, css_q, csc_q;
  fx_t  p2_c1c2_q, p2_c1c3_q, p2_c2c3_q, p2_c2s3_q, p2_c1s3_q;
  fx_t  p2_s1c2_q, p2_s1c3_q, p2_s1s3_q, p2_s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= cor_vld[CORDIC_STAGES];
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1c2_q    <= mulq(c1, c2);
      c1c3_q    <= mulq(c1, c3);
      c2c3_q    <= mulq(c2, c3);
      s1s2_q    <= mulq(s1, s2);
      c2s3_q    <= mulq(c2, s3);
      c1s3_q    <= mulq(c1, s3);
      s1c2_q    <= mulq(s1, c2);
      s1c3_q    <= mulq(s1, c3);
      c1s2_q    <= mulq(c1, s2);
      s1s3_q    <= mulq(s1, s3);
      p1_s2_q   <= s2;
      p1_s3_q   <= s3;
      p1_c3_q   <= c3;
      sss_q     <= mulq(s1s2_q, p1_s3_q);
      ssc_q     <= mulq(s1s2_q, p1_c3_q);
      css_q     <= mulq(c1s2_q, p1_s3_q);
      csc_q     <= mulq(c1s2_q, p1_c3_q);
      p2_c1c2_q <= c1c2_q;
      p2_c1c3_q <= c1c3_q;
      p2_c2c3_q <= c2c3_q;
      p2_c2s3_q <= c2s3_q;
      p2_c1s3_q <= c1s3_q;
      p2_s1c2_q <= s1c2_q;
      p2_s1c3_q <= s1c3_q;
      p2_s1s3_q <= s1s3_q;
      p2_s2_q   <= p1_s2_q;
    end
  end

  // sums: root argument and the three numerators, seeding the root row
  fx_t r_sum;
  sq_t sq_data [0:32];
  logic sq_vld [0:32];

  assign r_sum = FX_ONE + p2_c1c2_q + p2_c1c3_q - sss_q + p2_c2c3_q;
  assign sq_vld[0] = p3_vld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_data[0].nonpos <= (r_sum <= 0);
      sq_data[0].rem    <= (r_sum > 0) ? (64'(r_sum) << 30) : '0;
      sq_data[0].root   <= '0;
      sq_data[0].num[0] <= p2_c2s3_q + p2_c1s3_q + ssc_q;
      sq_data[0].num[1] <= p2_s1c2_q + p2_s1c3_q + css_q;
      sq_data[0].num[2] <= csc_q + p2_s2_q - p2_s1s3_q;
    end
  end

  for (genvar g = 0; g < 32; g++) begin : g_sqrt
    euq_sqrt_cell #(.STEP(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_vld[g]),
      .data_i  (sq_data[g]),
      .valid_o (sq_vld[g+1]),
      .data_o  (sq_data[g+1])
    );
  end

  // divide setup: w, divisor 2*root, rounded numerators, saturation check
  logic [31:0] root;
  logic [32:0] w_sum;
  logic [30:0] w_val;
  logic [32:0] den;
  dv_t         dv_seed;
  dv_t         dv_data [0:QF+1];
  logic        dv_vld  [0:QF+1];
  logic [32:0] mag [LANES];
  logic [63:0] numer [LANES];

  assign root  = sq_data[32].root[31:0];
  assign w_sum = 33'(root) + (33'd1 << (30 - QF));
  assign w_val = 31'(w_sum >> (31 - QF));
  assign den   = {root, 1'b0};

  always_comb begin
    dv_seed.den = den;
    dv_seed.deg = sq_data[32].nonpos || (root[31:1] == '0);
    dv_seed.w   = (w_val > LIM) ? LIM : w_val;
    for (int l = 0; l < LANES; l++) begin
      mag[l]   = sq_data[32].num[l][CW-1] ? 33'(-sq_data[32].num[l]) : 33'(sq_data[32].num[l]);
      numer[l] = (64'(mag[l]) << QF) + 64'(root);
      dv_seed.lane[l].neg = sq_data[32].num[l][CW-1];
      dv_seed.lane[l].rem = numer[l];
      dv_seed.lane[l].quo = '0;
      dv_seed.lane[l].sat = ({2'b00, numer[l]} >= (66'(den) << (QF + 1)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= sq_vld[32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_data[0] <= dv_seed;
    end
  end

  for (genvar g = 0; g <= QF; g++) begin : g_div
    euq_div_cell #(.QBIT(QF - g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_vld[g]),
      .data_i  (dv_data[g]),
      .valid_o (dv_vld[g+1]),
      .data_o  (dv_data[g+1])
    );
  end

  // clamp, sign and output register
  logic [30:0] qmag [LANES];
  logic [31:0] qval [LANES];
  logic        out_vld_q;
  logic [14:0] w_q;
  logic [15:0] x_q, y_q, z_q;
  logic        deg_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      qmag[l] = (dv_data[QF+1].lane[l].sat || dv_data[QF+1].lane[l].quo > LIM)
                ? LIM : dv_data[QF+1].lane[l].quo;
      qval[l] = dv_data[QF+1].lane[l].neg ? (32'd0 - {1'b0, qmag[l]}) : {1'b0, qmag[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld[QF+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_q <= dv_data[QF+1].deg;
      w_q   <= dv_data[QF+1].deg ? '0 : dv_data[QF+1].w[14:0];
      x_q   <= dv_data[QF+1].deg ? '0 : qval[0][15:0];
      y_q   <= dv_data[QF+1].deg ? '0 : qval[1][15:0];
      z_q   <= dv_data[QF+1].deg ? '0 : qval[2][15:0];
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.quat_w     = w_q;
  assign out_o.quat_x     = x_q;
  assign out_o.quat_y     = y_q;
  assign out_o.quat_z     = z_q;
  assign out_o.degenerate = deg_q;

  // a held result blocks the input side
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while result stalled");

  // degenerate results carry all-zero components
  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.degenerate |->
      out_o.quat_w == '0 && out_o.quat_x == '0 && out_o.quat_y == '0 && out_o.quat_z == '0)
    else $error("degenerate result with nonzero component");

  // a stalled row keeps the valid bit of its last divide cell unchanged
  a_row_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_vld[QF+1]))
    else $error("divide row moved during stall");

endmodule
